// ===== design/isa_pkg.sv =====
// isa_pkg: shared types, constants and helpers for the imu sample averager
// no dependencies
`timescale 1ns / 1ps
package isa_pkg;
  localparam int CAL_SAMPLES_DEF = 25;
  localparam int NUM_AXES = 3;
  localparam int SAMPLE_W = 16;
  localparam int SUM_W = 26;
  localparam int CNT_W = 9;
  localparam int QUO_W = 26;

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_CALIB = 1'b1;

  localparam logic [1:0] REG_AVG_EN = 2'd0;
  localparam logic [1:0] REG_AVG_CNT = 2'd1;
  localparam logic [1:0] REG_CAL_EN = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // input beat: operation bit then six raw axes
  typedef struct packed {
    logic operation;
    sample_t accel_x_raw;
    sample_t accel_y_raw;
    sample_t accel_z_raw;
    sample_t gyro_x_raw;
    sample_t gyro_y_raw;
    sample_t gyro_z_raw;
  } imu_in_t;

  // output beat: six conditioned axes
  typedef struct packed {
    sample_t accel_x_out;
    sample_t accel_y_out;
    sample_t accel_z_out;
    sample_t gyro_x_out;
    sample_t gyro_y_out;
    sample_t gyro_z_out;
  } imu_out_t;

  typedef struct packed {
    logic start;
    logic [CNT_W-1:0] divisor;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic sample_t sat16(input logic signed [SUM_W:0] v);
    if (v > $signed((SUM_W+1)'(32767))) return sample_t'(16'sd32767);
    if (v < -$signed((SUM_W+1)'(32768))) return sample_t'(-16'sd32768);
    return sample_t'(v[SAMPLE_W-1:0]);
  endfunction
endpackage

// ===== design/isa_stream_if.sv =====
// isa_stream_if: valid/ready channel carrying a payload of type T
// depends on nothing
`timescale 1ns / 1ps
interface isa_stream_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/isa_div_lane.sv =====
// isa_div_lane: one lane, restoring signed division of a sum by a count
// depends on isa_pkg
`timescale 1ns / 1ps
module isa_div_lane (
  input logic clk,
  input logic rst,
  input isa_pkg::div_ctrl_t ctrl,
  input logic signed [isa_pkg::SUM_W-1:0] dividend,
  output isa_pkg::div_stat_t stat,
  output logic signed [isa_pkg::SUM_W:0] quotient
);
  import isa_pkg::*;
  localparam int STEP_W = $clog2(QUO_W + 1);

  logic [QUO_W-1:0] quo;
  logic [CNT_W:0] rem;
  logic [CNT_W-1:0] dvs;
  logic negative;
  logic [STEP_W-1:0] step;
  logic busy;
  logic done;
  logic [CNT_W:0] rem_shift;
  logic [QUO_W-1:0] mag;

  assign mag = dividend[SUM_W-1] ? QUO_W'(-dividend) : QUO_W'(dividend);
  assign rem_shift = {rem[CNT_W-1:0], quo[QUO_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        step <= STEP_W'(QUO_W);
        quo <= mag;
        rem <= '0;
        dvs <= ctrl.divisor;
        negative <= dividend[SUM_W-1];
      end else if (busy) begin
        if (rem_shift >= {1'b0, dvs}) begin
          rem <= rem_shift - {1'b0, dvs};
          quo <= {quo[QUO_W-2:0], 1'b1};
        end else begin
          rem <= rem_shift;
          quo <= {quo[QUO_W-2:0], 1'b0};
        end
        step <= step - 1'b1;
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // zero divisor gives zero
  assign quotient = (dvs == '0) ? '0 :
                    negative ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign stat = '{busy: busy, done: done};
endmodule

// ===== design/imu_sample_averager_with_offset_top.sv =====
// imu_sample_averager_with_offset_top: six-axis block averager with accel offset
// depends on isa_pkg, isa_stream_if, isa_div_lane
// direct result is registered, valid in the cycle after its beat; an accumulate beat leaves the input ready
// flush result is valid once the lanes finish dividing; an offset latch completes in the same way
// one beat at a time; a flush or latch keeps the lanes busy and the input not ready while dividing
// reset: synchronous active-high rst clears sums, counts, offsets and registers
`timescale 1ns / 1ps
module imu_sample_averager_with_offset_top #(
  parameter int CAL_SAMPLES = isa_pkg::CAL_SAMPLES_DEF
) (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [1:0] cfg_index,
  input logic [7:0] cfg_data,
  isa_stream_if.sink in_s,
  isa_stream_if.source out_s
);
  import isa_pkg::*;
  localparam int CC_W = $clog2(CAL_SAMPLES + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_OUT} state_t;

  // payload layout: operation, accel x,y,z, gyro x,y,z
  state_t state;
  logic averaging_enable;
  logic [7:0] average_count;
  logic calibration_enable;

  logic signed [SUM_W-1:0] accel_sums [NUM_AXES];
  logic signed [SUM_W-1:0] gyro_sums [NUM_AXES];
  logic [CNT_W-1:0] sample_count;
  sample_t offset_values [NUM_AXES];
  logic signed [SUM_W-1:0] calib_sums [NUM_AXES];
  logic [CC_W-1:0] calib_count;
  logic is_cal_div;

  sample_t acc_in [NUM_AXES];
  sample_t gyr_in [NUM_AXES];
  logic signed [SAMPLE_W:0] cond [NUM_AXES];
  logic signed [SUM_W-1:0] lane_div [2*NUM_AXES];
  logic signed [SUM_W:0] lane_quo [2*NUM_AXES];
  div_stat_t lane_stat [2*NUM_AXES];
  div_ctrl_t ctrl;
  sample_t res [2*NUM_AXES];
  logic accept;

  assign acc_in[0] = in_s.payload.accel_x_raw;
  assign acc_in[1] = in_s.payload.accel_y_raw;
  assign acc_in[2] = in_s.payload.accel_z_raw;
  assign gyr_in[0] = in_s.payload.gyro_x_raw;
  assign gyr_in[1] = in_s.payload.gyro_y_raw;
  assign gyr_in[2] = in_s.payload.gyro_z_raw;

  assign in_s.ready = (state == ST_IDLE);
  assign accept = in_s.valid && in_s.ready;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      cond[i] = calibration_enable ?
                (SAMPLE_W+1)'(offset_values[i]) - (SAMPLE_W+1)'(acc_in[i]) :
                (SAMPLE_W+1)'(acc_in[i]);
    end
  end

  // six lanes: three accel, three gyro; calibration latch reuses accel lanes
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      lane_div[i] = is_cal_div ? calib_sums[i] : accel_sums[i];
      lane_div[NUM_AXES+i] = gyro_sums[i];
    end
  end

  for (genvar g = 0; g < 2*NUM_AXES; g++) begin : g_lane
    isa_div_lane u_lane (
      .clk(clk), .rst(rst), .ctrl(ctrl), .dividend(lane_div[g]),
      .stat(lane_stat[g]), .quotient(lane_quo[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      averaging_enable <= 1'b0;
      average_count <= '0;
      calibration_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AVG_EN: averaging_enable <= cfg_data[0];
        REG_AVG_CNT: average_count <= cfg_data;
        REG_CAL_EN: calibration_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_s.valid <= 1'b0;
      ctrl <= '0;
      sample_count <= '0;
      calib_count <= '0;
      is_cal_div <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        accel_sums[i] <= '0;
        gyro_sums[i] <= '0;
        calib_sums[i] <= '0;
        offset_values[i] <= '0;
      end
    end else begin
      ctrl.start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_s.payload.operation == OP_CALIB) begin
              for (int i = 0; i < NUM_AXES; i++)
                calib_sums[i] <= calib_sums[i] + SUM_W'(acc_in[i]);
              if (32'(calib_count) + 1 >= CAL_SAMPLES) begin
                calib_count <= '0;
                is_cal_div <= 1'b1;
                ctrl <= '{start: 1'b1, divisor: CNT_W'(CAL_SAMPLES)};
                state <= ST_DIV;
              end else begin
                calib_count <= calib_count + 1'b1;
              end
            end else if (!averaging_enable) begin
              for (int i = 0; i < NUM_AXES; i++) begin
                res[i] <= sat16((SUM_W+1)'(cond[i]));
                res[NUM_AXES+i] <= gyr_in[i];
              end
              out_s.valid <= 1'b1;
              state <= ST_OUT;
            end else if (sample_count <= {1'b0, average_count}) begin
              for (int i = 0; i < NUM_AXES; i++) begin
                accel_sums[i] <= accel_sums[i] + SUM_W'(cond[i]);
                gyro_sums[i] <= gyro_sums[i] + SUM_W'(gyr_in[i]);
              end
              sample_count <= sample_count + 1'b1;
            end else begin
              is_cal_div <= 1'b0;
              ctrl <= '{start: 1'b1, divisor: sample_count};
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (lane_stat[0].done) begin
            if (is_cal_div) begin
              for (int i = 0; i < NUM_AXES; i++) begin
                offset_values[i] <= sample_t'(lane_quo[i][SAMPLE_W-1:0]);
                calib_sums[i] <= '0;
              end
              state <= ST_IDLE;
            end else begin
              for (int i = 0; i < 2*NUM_AXES; i++) res[i] <= sat16(lane_quo[i]);
              for (int i = 0; i < NUM_AXES; i++) begin
                accel_sums[i] <= '0;
                gyro_sums[i] <= '0;
              end
              sample_count <= '0;
              out_s.valid <= 1'b1;
              state <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (out_s.ready) begin
            out_s.valid <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_s.payload.accel_x_out = res[0];
  assign out_s.payload.accel_y_out = res[1];
  assign out_s.payload.accel_z_out = res[2];
  assign out_s.payload.gyro_x_out = res[3];
  assign out_s.payload.gyro_y_out = res[4];
  assign out_s.payload.gyro_z_out = res[5];

  // lanes run in lock step
  a_lanes_sync: assert property (@(posedge clk) disable iff (rst)
    lane_stat[0].busy == lane_stat[5].busy) else $error("lanes out of step");
  // no beat taken while dividing
  a_no_accept_div: assert property (@(posedge clk) disable iff (rst)
    lane_stat[0].busy |-> !in_s.ready) else $error("accept during divide");
  // a result only leaves from the output state
  a_valid_state: assert property (@(posedge clk) disable iff (rst)
    out_s.valid |-> state == ST_OUT) else $error("valid outside output state");
  // calibration count stays below its limit
  a_cal_cnt: assert property (@(posedge clk) disable iff (rst)
    32'(calib_count) < CAL_SAMPLES) else $error("calib count overflow");
endmodule

// ===== test/tb_imu_sample_averager_with_offset_top.sv =====
// tb_imu_sample_averager_with_offset_top: self-checking bench for the six-axis averager
// depends on isa_pkg, isa_stream_if and imu_sample_averager_with_offset_top
`timescale 1ns / 1ps
module tb_imu_sample_averager_with_offset_top;
  import isa_pkg::*;

  localparam int CAL_N = CAL_SAMPLES_DEF;
  localparam int SETTLE_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_AVG_EN;
  logic [7:0] cfg_data = 8'd0;

  isa_stream_if #(.T(imu_in_t)) in_s (.clk(clk));
  isa_stream_if #(.T(imu_out_t)) out_s (.clk(clk));

  imu_sample_averager_with_offset_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_s(in_s.sink),
    .out_s(out_s.source)
  );

  always #5 clk = ~clk;

  // shadow copy of the block's registers and state
  bit mdl_avg_en;
  int mdl_avg_cnt;
  bit mdl_cal_en;
  longint acc_sum[3];
  longint gyr_sum[3];
  int acc_n;
  int gyr_n;
  longint offs[3];
  longint cal_sum[3];
  int cal_n;

  imu_out_t pending_results[$];
  int fail_count = 0;

  // idle knobs: send idle and receive stall in percent, plus a receiver hold-off length
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;

  initial begin
    in_s.valid = 1'b0;
    in_s.payload = '0;
    out_s.ready = 1'b0;
  end

  function automatic sample_t clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return sample_t'(v);
  endfunction

  // runs one accepted beat through the shadow state
  function automatic void predict_beat(imu_in_t b);
    longint raw_a[3];
    longint raw_g[3];
    longint cond[3];
    imu_out_t r;
    bit gflush;
    bit aflush;
    longint ares[3];
    longint gres[3];
    raw_a[0] = b.accel_x_raw; raw_a[1] = b.accel_y_raw; raw_a[2] = b.accel_z_raw;
    raw_g[0] = b.gyro_x_raw; raw_g[1] = b.gyro_y_raw; raw_g[2] = b.gyro_z_raw;
    gflush = 0;
    aflush = 0;
    if (b.operation == OP_CALIB) begin
      for (int i = 0; i < 3; i++) cal_sum[i] += raw_a[i];
      cal_n++;
      if (cal_n >= CAL_N) begin
        // truncating divide, sums restart
        for (int i = 0; i < 3; i++) begin
          offs[i] = cal_sum[i] / CAL_N;
          cal_sum[i] = 0;
        end
        cal_n = 0;
      end
      return;
    end
    for (int i = 0; i < 3; i++) cond[i] = mdl_cal_en ? offs[i] - raw_a[i] : raw_a[i];
    if (!mdl_avg_en) begin
      r.accel_x_out = clamp16(cond[0]);
      r.accel_y_out = clamp16(cond[1]);
      r.accel_z_out = clamp16(cond[2]);
      r.gyro_x_out = sample_t'(raw_g[0]);
      r.gyro_y_out = sample_t'(raw_g[1]);
      r.gyro_z_out = sample_t'(raw_g[2]);
      pending_results.push_back(r);
      return;
    end
    for (int i = 0; i < 3; i++) begin
      ares[i] = 0;
      gres[i] = 0;
    end
    if (gyr_n <= mdl_avg_cnt) begin
      for (int i = 0; i < 3; i++) gyr_sum[i] += raw_g[i];
      gyr_n++;
    end else begin
      gflush = 1;
      for (int i = 0; i < 3; i++) begin
        if (gyr_n != 0) gres[i] = gyr_sum[i] / gyr_n;
        gyr_sum[i] = 0;
      end
      gyr_n = 0;
    end
    if (acc_n <= mdl_avg_cnt) begin
      for (int i = 0; i < 3; i++) acc_sum[i] += cond[i];
      acc_n++;
    end else begin
      aflush = 1;
      for (int i = 0; i < 3; i++) begin
        if (acc_n != 0) ares[i] = acc_sum[i] / acc_n;
        acc_sum[i] = 0;
      end
      acc_n = 0;
    end
    if (!aflush) return;
    r.accel_x_out = clamp16(ares[0]);
    r.accel_y_out = clamp16(ares[1]);
    r.accel_z_out = clamp16(ares[2]);
    r.gyro_x_out = gflush ? clamp16(gres[0]) : '0;
    r.gyro_y_out = gflush ? clamp16(gres[1]) : '0;
    r.gyro_z_out = gflush ? clamp16(gres[2]) : '0;
    pending_results.push_back(r);
  endfunction

  // register write, block must be idle
  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_AVG_EN: mdl_avg_en = val[0];
      REG_AVG_CNT: mdl_avg_cnt = val;
      REG_CAL_EN: mdl_cal_en = val[0];
      default: ;
    endcase
  endtask

  // offers one beat and waits for it to be taken
  task automatic send_beat(imu_in_t b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_s.valid = 1'b0;
      @(negedge clk);
    end
    in_s.valid = 1'b1;
    in_s.payload = b;
    forever begin
      @(posedge clk);
      if (in_s.ready) break;
    end
    predict_beat(b);
  endtask

  // drain results, then let a silent offset latch finish
  task automatic wait_idle();
    @(negedge clk);
    in_s.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic sample_t rand_axis();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return sample_t'($urandom_range(15)) - 16'sd8;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic imu_in_t make_beat(logic op);
    imu_in_t b;
    b.operation = op;
    b.accel_x_raw = rand_axis(); b.accel_y_raw = rand_axis(); b.accel_z_raw = rand_axis();
    b.gyro_x_raw = rand_axis(); b.gyro_y_raw = rand_axis(); b.gyro_z_raw = rand_axis();
    return b;
  endfunction

  function automatic imu_in_t all_axes(logic op, sample_t v);
    imu_in_t b;
    b.operation = op;
    b.accel_x_raw = v; b.accel_y_raw = v; b.accel_z_raw = v;
    b.gyro_x_raw = v; b.gyro_y_raw = v; b.gyro_z_raw = v;
    return b;
  endfunction

  // receiver: random stall, or a long hold-off when asked
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_s.ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_s.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk) begin
    if (!rst && out_s.valid && out_s.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, out_s.payload);
        fail_count++;
      end else begin
        imu_out_t want;
        want = pending_results.pop_front();
        if (out_s.payload.accel_x_out !== want.accel_x_out ||
            out_s.payload.accel_y_out !== want.accel_y_out ||
            out_s.payload.accel_z_out !== want.accel_z_out ||
            out_s.payload.gyro_x_out !== want.gyro_x_out ||
            out_s.payload.gyro_y_out !== want.gyro_y_out ||
            out_s.payload.gyro_z_out !== want.gyro_z_out) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, out_s.payload);
          fail_count++;
        end
      end
    end
  end

  // direct pass: field extremes with offsets still zero
  task automatic test_direct_extremes();
    write_reg(REG_AVG_EN, 8'd0);
    write_reg(REG_CAL_EN, 8'd0);
    write_reg(REG_AVG_CNT, 8'd0);
    send_beat(all_axes(OP_MEASURE, 16'sh7fff));
    send_beat(all_axes(OP_MEASURE, 16'sh8000));
    send_beat(all_axes(OP_MEASURE, 16'sh0000));
    send_beat(all_axes(OP_MEASURE, 16'shffff));
    send_beat(make_beat(OP_MEASURE));
    wait_idle();
  endtask

  // calibrate at full scale, then offset minus raw saturates both ways
  task automatic test_calibration();
    for (int i = 0; i < CAL_N; i++) send_beat(all_axes(OP_CALIB, 16'sh7fff));
    wait_idle();
    write_reg(REG_CAL_EN, 8'd1);
    send_beat(all_axes(OP_MEASURE, 16'sh8000));
    send_beat(all_axes(OP_MEASURE, 16'sh7fff));
    send_beat(all_axes(OP_MEASURE, 16'sh0001));
    wait_idle();
    for (int i = 0; i < CAL_N; i++) send_beat(all_axes(OP_CALIB, 16'sh8000));
    wait_idle();
    send_beat(all_axes(OP_MEASURE, 16'sh7fff));
    // calibration beats mixed in do not touch averaging
    send_beat(all_axes(OP_CALIB, 16'sh1234));
    wait_idle();
  endtask

  // averaging at count zero, mode change mid-block, count lowered mid-block
  task automatic test_averaging();
    write_reg(REG_AVG_EN, 8'd1);
    write_reg(REG_AVG_CNT, 8'd0);
    send_beat(all_axes(OP_MEASURE, 16'sh7fff));
    send_beat(all_axes(OP_MEASURE, 16'sh7fff));
    send_beat(make_beat(OP_MEASURE));
    wait_idle();
    write_reg(REG_AVG_CNT, 8'd5);
    send_beat(make_beat(OP_MEASURE));
    send_beat(make_beat(OP_MEASURE));
    wait_idle();
    write_reg(REG_AVG_EN, 8'd0);
    send_beat(make_beat(OP_MEASURE));
    wait_idle();
    write_reg(REG_AVG_EN, 8'd1);
    send_beat(make_beat(OP_MEASURE));
    wait_idle();
    write_reg(REG_AVG_CNT, 8'd1);
    send_beat(make_beat(OP_MEASURE));
    wait_idle();
  endtask

  // one long block at the largest count
  task automatic test_max_count();
    write_reg(REG_CAL_EN, 8'd0);
    write_reg(REG_AVG_EN, 8'd1);
    write_reg(REG_AVG_CNT, 8'd255);
    for (int i = 0; i < 258; i++) send_beat(all_axes(OP_MEASURE, 16'sh8000));
    wait_idle();
  endtask

  // random beats under one idle setting with random registers
  task automatic test_random_phase(int n, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    write_reg(REG_AVG_EN, 8'($urandom_range(1)));
    write_reg(REG_AVG_CNT, ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(7)));
    write_reg(REG_CAL_EN, 8'($urandom_range(1)));
    for (int i = 0; i < n; i++)
      send_beat(make_beat($urandom_range(4) == 0 ? OP_CALIB : OP_MEASURE));
    wait_idle();
  endtask

  // receiver holds off while beats keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(REG_AVG_EN, 8'd0);
    @(negedge clk);
    hold_off_cycles = 300;
    for (int i = 0; i < 20; i++) send_beat(make_beat(OP_MEASURE));
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_direct_extremes();
    test_calibration();
    test_averaging();
    test_backpressure();
    test_max_count();
    test_random_phase(20, 0, 0);
    test_random_phase(20, 57, 0);
    test_random_phase(20, 0, 57);
    test_random_phase(20, 11, 11);
    recv_stall_pct = 0;
    wait_idle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit well above the slowest correct run
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
design/isa_pkg.sv
design/isa_stream_if.sv
design/isa_div_lane.sv
design/imu_sample_averager_with_offset_top.sv
test/tb_imu_sample_averager_with_offset_top.sv
